### rtl/core/gtg_pkg.sv
package gtg_pkg;

    typedef struct packed {
        logic        cmd;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] heading;
    } in_req_t;

    typedef struct packed {
        logic        goal_set;
        logic [15:0] angle_error;
        logic [15:0] along_error;
    } out_req_t;

    localparam int CORDIC_N = 16;
    localparam int IW = 5;      // iteration counter width, holds CORDIC_N
    localparam int VW = 36;     // CORDIC vector datapath width
    localparam int AW = 22;     // angle width, 2^-16 rad units

    localparam logic signed [AW-1:0] ANG_PI      = 22'sd205887;
    localparam logic signed [AW-1:0] ANG_HALF_PI = 22'sd102944;
    localparam logic [15:0]          INV_GAIN    = 16'd39797;

    localparam logic CMD_GOAL = 1'b0;
    localparam logic CMD_POSE = 1'b1;

    // Work item handed from the front to the back: the error vector and heading.
    typedef struct packed {
        logic               goal_set;
        logic signed [16:0] ex;
        logic signed [16:0] ey;
        logic signed [15:0] h;
    } work_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ITER,
        ST_MUL,
        ST_DONE
    } back_state_t;

    function automatic logic signed [AW-1:0] atan_entry(input logic [IW-2:0] i);
        logic signed [AW-1:0] r;
        begin
            case (i)
                4'd0:    r = 22'sd51472;
                4'd1:    r = 22'sd30386;
                4'd2:    r = 22'sd16055;
                4'd3:    r = 22'sd8150;
                4'd4:    r = 22'sd4091;
                4'd5:    r = 22'sd2047;
                4'd6:    r = 22'sd1024;
                4'd7:    r = 22'sd512;
                4'd8:    r = 22'sd256;
                4'd9:    r = 22'sd128;
                4'd10:   r = 22'sd64;
                4'd11:   r = 22'sd32;
                4'd12:   r = 22'sd16;
                4'd13:   r = 22'sd8;
                4'd14:   r = 22'sd4;
                default: r = 22'sd2;
            endcase
            return r;
        end
    endfunction

endpackage

### rtl/core/gtg_front.sv
module gtg_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  gtg_pkg::in_req_t in_data,
    output logic             wq_valid,
    input  logic             wq_full,
    output gtg_pkg::work_t   wq_data
);
    import gtg_pkg::*;

    logic [15:0] goal_x_reg, goal_y_reg, cur_x_reg, cur_y_reg, cur_h_reg;
    logic        goal_valid_reg;
    logic [15:0] gx, gy, cx, cy, ch;
    logic        gv;

    assign in_stall = wq_full;

    // Stored state as it stands after the request being accepted now.
    always_comb
    begin
        gx = goal_x_reg;
        gy = goal_y_reg;
        gv = goal_valid_reg;
        cx = cur_x_reg;
        cy = cur_y_reg;
        ch = cur_h_reg;
        if (in_data.cmd == CMD_GOAL)
        begin
            gx = in_data.pos_x;
            gy = in_data.pos_y;
            gv = 1'b1;
        end
        else
        begin
            cx = in_data.pos_x;
            cy = in_data.pos_y;
            ch = in_data.heading;
        end
    end

    assign wq_valid         = in_valid && !wq_full;
    assign wq_data.goal_set = gv;
    assign wq_data.ex       = 17'(signed'(gx)) - 17'(signed'(cx));
    assign wq_data.ey       = 17'(signed'(gy)) - 17'(signed'(cy));
    assign wq_data.h        = signed'(ch);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            goal_valid_reg <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            cur_h_reg      <= '0;
        end
        else if (wq_valid)
        begin
            goal_x_reg     <= gx;
            goal_y_reg     <= gy;
            goal_valid_reg <= gv;
            cur_x_reg      <= cx;
            cur_y_reg      <= cy;
            cur_h_reg      <= ch;
        end
    end
endmodule

### rtl/core/gtg_queue.sv
module gtg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gtg_pkg::work_t push_data,
    output logic           full,
    output logic           pop_valid,
    input  logic           pop,
    output gtg_pkg::work_t pop_data
);
    import gtg_pkg::*;

    work_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign pop_valid = cnt_reg != 2'd0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

### rtl/core/gtg_back.sv
module gtg_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wq_valid,
    output logic              wq_pop,
    input  gtg_pkg::work_t    wq_data,
    output logic              out_valid,
    input  logic              out_stall,
    output gtg_pkg::out_req_t out_data
);
    import gtg_pkg::*;

    back_state_t state_reg, state_next;
    logic [IW-1:0] it_reg;
    // Vectoring unit (bearing) and rotation unit (projection) run side by side.
    logic signed [VW-1:0] vx_reg, vy_reg, rx_reg, ry_reg;
    logic signed [AW-1:0] vz_reg, rz_reg;
    logic                 zero_reg, gs_reg;
    logic signed [15:0]   h_reg;
    logic signed [VW+16:0] prod_reg;
    out_req_t             res_reg;
    logic                 res_valid_reg;

    logic [IW-2:0]        idx;
    logic signed [VW-1:0] vxs, vys, rxs, rys;
    logic signed [AW-1:0] at;
    logic signed [VW-1:0] ex0, ey0;
    logic signed [AW-1:0] a0;
    logic signed [AW+1:0] hn;
    logic                 take, ld_out;
    logic signed [AW-1:0] brg_q;
    logic signed [AW:0]   ang_w;
    logic signed [VW-12:0] al_w;
    logic signed [15:0]   ang_s, al_s;

    assign idx = it_reg[IW-2:0];
    assign at  = atan_entry(idx);
    assign vxs = vx_reg >>> idx;
    assign vys = vy_reg >>> idx;
    assign rxs = rx_reg >>> idx;
    assign rys = ry_reg >>> idx;

    assign ex0 = VW'(wq_data.ex) <<< 12;
    assign ey0 = VW'(wq_data.ey) <<< 12;
    // Heading in Q3.12 is at most about 8 rad, so three half turns fold it.
    assign hn  = -((AW+2)'(wq_data.h) <<< 4);

    always_comb
    begin
        a0 = AW'(hn);
        if (hn > (AW+2)'(ANG_HALF_PI))
        begin
            if (hn - (AW+2)'(ANG_PI) > (AW+2)'(ANG_HALF_PI))
            begin
                if (hn - 2*(AW+2)'(ANG_PI) > (AW+2)'(ANG_HALF_PI))
                    a0 = AW'(hn - 3*(AW+2)'(ANG_PI));
                else
                    a0 = AW'(hn - 2*(AW+2)'(ANG_PI));
            end
            else
                a0 = AW'(hn - (AW+2)'(ANG_PI));
        end
        else if (hn < -(AW+2)'(ANG_HALF_PI))
        begin
            if (hn + (AW+2)'(ANG_PI) < -(AW+2)'(ANG_HALF_PI))
            begin
                if (hn + 2*(AW+2)'(ANG_PI) < -(AW+2)'(ANG_HALF_PI))
                    a0 = AW'(hn + 3*(AW+2)'(ANG_PI));
                else
                    a0 = AW'(hn + 2*(AW+2)'(ANG_PI));
            end
            else
                a0 = AW'(hn + (AW+2)'(ANG_PI));
        end
    end

    logic neg_rot;
    always_comb
    begin
        logic signed [AW+1:0] d;
        d = hn - (AW+2)'(a0);
        // Odd number of half turns flips the vector.
        neg_rot = (d == (AW+2)'(ANG_PI)) || (d == -(AW+2)'(ANG_PI))
               || (d == 3*(AW+2)'(ANG_PI)) || (d == -3*(AW+2)'(ANG_PI));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (wq_valid && (!res_valid_reg || !out_stall)) state_next = ST_PREP;
            ST_PREP: state_next = ST_ITER;
            ST_ITER: if (it_reg == IW'(CORDIC_N - 1)) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DONE;
            ST_DONE: if (!res_valid_reg || !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        take   = 1'b0;
        ld_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: take = wq_valid && (!res_valid_reg || !out_stall);
            ST_DONE: ld_out = !res_valid_reg || !out_stall;
            default: ;
        endcase
    end

    assign wq_pop = take;

    assign brg_q = (vz_reg + AW'(8)) >>> 4;
    assign ang_w = (AW+1)'(brg_q) - (AW+1)'(h_reg);
    assign ang_s = (ang_w > 32767) ? 16'sh7fff : (ang_w < -32768) ? 16'sh8000 : 16'(ang_w);
    assign al_w  = (VW-11)'((prod_reg + (53'sd1 <<< 27)) >>> 28);
    assign al_s  = (al_w > 32767) ? 16'sh7fff : (al_w < -32768) ? 16'sh8000 : 16'(al_w);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            gs_reg   <= wq_data.goal_set;
            h_reg    <= wq_data.h;
            zero_reg <= (wq_data.ex == 0) && (wq_data.ey == 0);
            if (wq_data.ex < 0)
            begin
                vx_reg <= -ex0;
                vy_reg <= -ey0;
                vz_reg <= (wq_data.ey >= 0) ? ANG_PI : -ANG_PI;
            end
            else
            begin
                vx_reg <= ex0;
                vy_reg <= ey0;
                vz_reg <= '0;
            end
            rx_reg <= neg_rot ? -ex0 : ex0;
            ry_reg <= neg_rot ? -ey0 : ey0;
            rz_reg <= a0;
            it_reg <= '0;
        end
        else if (state_reg == ST_ITER)
        begin
            if (vy_reg >= 0)
            begin
                vx_reg <= vx_reg + vys;
                vy_reg <= vy_reg - vxs;
                vz_reg <= vz_reg + at;
            end
            else
            begin
                vx_reg <= vx_reg - vys;
                vy_reg <= vy_reg + vxs;
                vz_reg <= vz_reg - at;
            end
            if (rz_reg >= 0)
            begin
                rx_reg <= rx_reg - rys;
                ry_reg <= ry_reg + rxs;
                rz_reg <= rz_reg - at;
            end
            else
            begin
                rx_reg <= rx_reg + rys;
                ry_reg <= ry_reg - rxs;
                rz_reg <= rz_reg + at;
            end
            it_reg <= it_reg + IW'(1);
        end
        else if (state_reg == ST_MUL)
        begin
            prod_reg <= (VW+17)'(rx_reg) * (VW+17)'(signed'({1'b0, INV_GAIN}));
            if (zero_reg)
                vz_reg <= '0;
        end
        if (ld_out)
        begin
            res_reg.goal_set    <= gs_reg;
            res_reg.angle_error <= gs_reg ? ang_s : '0;
            res_reg.along_error <= gs_reg ? al_s : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ld_out)
                res_valid_reg <= 1'b1;
            else if (!out_stall)
                res_valid_reg <= 1'b0;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;
endmodule

### rtl/core/go_to_goal_pose_error.sv
// Go-to-goal pose error. Each input request is a new goal (cmd = 0) or a new
// measured pose (cmd = 1); the block stores it and returns one result request
// with the heading error (bearing to goal minus heading, Q3.12, not wrapped,
// saturated) and the goal distance projected on the heading (Q8.8, saturated).
// Before any goal arrives, results are all zero with goal_set low. The front
// stores state and forms the error vector in the accept cycle; a two-entry
// queue feeds the back, where a vectoring and a rotation CORDIC share one
// 16-step iteration loop. That loop sets the rate: each request passes through
// prepare, the 16 iterations, gain multiply and output load before the back takes another.
module go_to_goal_pose_error (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gtg_pkg::in_req_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output gtg_pkg::out_req_t out_data
);
    import gtg_pkg::*;

    logic  push, full, q_valid, pop;
    work_t push_data, q_data;

    // The front writes the queue for every accepted request.
    gtg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .wq_valid (push),
        .wq_full  (full),
        .wq_data  (push_data)
    );

    gtg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop_valid (q_valid),
        .pop       (pop),
        .pop_data  (q_data)
    );

    // The back runs the CORDIC loop and holds the result register.
    gtg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wq_valid  (q_valid),
        .wq_pop    (pop),
        .wq_data   (q_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );
endmodule

### verif/go_to_goal_pose_error_tb.sv
`timescale 1ns / 100ps

module go_to_goal_pose_error_tb;

    import gtg_pkg::*;

    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  SETTLE_CYCLES  = 40;
    localparam int  HOLD_CYCLES    = 300;
    localparam longint PI_U16      = 205887;
    localparam longint HALF_PI_U16 = 102944;
    localparam longint GAIN_INV    = 39797;

    // Arctangent steps in 2^-16 rad units.
    localparam longint ATAN_STEP [16] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    in_req_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    out_req_t out_data;

    go_to_goal_pose_error u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor copy of the block's stored goal and pose.
    logic signed [15:0] model_goal_x;
    logic signed [15:0] model_goal_y;
    logic               model_goal_seen;
    logic signed [15:0] model_pose_x;
    logic signed [15:0] model_pose_y;
    logic signed [15:0] model_heading;

    out_req_t pending_errors [$];
    int       mismatch_count = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       hold_left = 0;
    bit       hold_go = 1'b0;
    int       quiet_cycles = 0;

    function automatic longint clamp16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Vectoring CORDIC: bearing of (x, y) in 2^-16 rad units.
    function automatic longint bearing_u16(input longint x, input longint y);
        longint z;
        longint nx;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_U16 : -PI_U16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_STEP[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_STEP[i];
            end
            x = nx;
        end
        return z;
    endfunction

    // Rotation CORDIC: x part of (x, y) turned by angle a, gain still applied.
    function automatic longint rotated_x(input longint x, input longint y, input longint a);
        longint nx;
        for (int i = 0; i < 8 && a > HALF_PI_U16; i++)
        begin
            a = a - PI_U16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 8 && a < -HALF_PI_U16; i++)
        begin
            a = a + PI_U16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (a >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                a  = a - ATAN_STEP[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                a  = a + ATAN_STEP[i];
            end
            x = nx;
        end
        return x;
    endfunction

    // Updates the stored goal or pose and returns the expected errors.
    function automatic out_req_t pose_error_of(input in_req_t req);
        out_req_t r;
        longint   ex;
        longint   ey;
        longint   h;
        longint   prod;
        r = '0;
        if (req.cmd == CMD_GOAL)
        begin
            model_goal_x    = req.pos_x;
            model_goal_y    = req.pos_y;
            model_goal_seen = 1'b1;
        end
        else
        begin
            model_pose_x  = req.pos_x;
            model_pose_y  = req.pos_y;
            model_heading = req.heading;
        end
        if (!model_goal_seen)
            return r;
        ex = (longint'(model_goal_x) - longint'(model_pose_x)) * 4096;
        ey = (longint'(model_goal_y) - longint'(model_pose_y)) * 4096;
        h  = longint'(model_heading);
        r.goal_set    = 1'b1;
        r.angle_error = 16'(clamp16(((bearing_u16(ex, ey) + 8) >>> 4) - h));
        prod          = rotated_x(ex, ey, -(h * 16)) * GAIN_INV;
        r.along_error = 16'(clamp16((prod + (longint'(1) <<< 27)) >>> 28));
        return r;
    endfunction

    // Offers one request, with an optional random gap first, and waits until
    // the block takes it. The valid line is left high on return; the drain lowers
    // it at the following falling edge, and the next call lowers it only for a gap.
    task automatic send_request(input in_req_t req);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        pending_errors.push_back(pose_error_of(req));
    endtask

    task automatic send_fields(input logic cmd, input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] h);
        in_req_t req;
        req.cmd     = cmd;
        req.pos_x   = x;
        req.pos_y   = y;
        req.heading = h;
        send_request(req);
    endtask

    // Lowers valid and waits for every outstanding result to come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_errors.size() != 0)
            @(posedge clk);
    endtask

    // Before any goal: results must be all zero with goal_set low.
    task automatic test_before_goal();
        send_fields(CMD_POSE, 16'h1234, 16'hF00D, 16'h0800);
        send_fields(CMD_POSE, 16'h7FFF, 16'h8000, 16'h8000);
        send_fields(CMD_POSE, 16'h0000, 16'h0000, 16'h7FFF);
    endtask

    // Field extremes, the robot sitting on the goal, all four quadrants of
    // the bearing including the negative-x branch on either side of the
    // y axis, and headings far enough from zero that the angle saturates.
    task automatic test_directed_cases();
        send_fields(CMD_GOAL, 16'h0000, 16'h0000, 16'h7FFF);
        send_fields(CMD_POSE, 16'h0000, 16'h0000, 16'h0000);
        send_fields(CMD_POSE, 16'h0100, 16'h0000, 16'h0000);
        send_fields(CMD_POSE, 16'hFF00, 16'h0000, 16'h0000);
        send_fields(CMD_POSE, 16'h0100, 16'hFF00, 16'h1000);
        send_fields(CMD_POSE, 16'h0100, 16'h0000, 16'hC000);
        send_fields(CMD_POSE, 16'h0000, 16'h0100, 16'h6488);
        send_fields(CMD_POSE, 16'h0000, 16'hFF00, 16'h9B78);
        send_fields(CMD_POSE, 16'h0000, 16'h0000, 16'h8000);
        send_fields(CMD_GOAL, 16'h7FFF, 16'h7FFF, 16'h0000);
        send_fields(CMD_POSE, 16'h8000, 16'h8000, 16'h0000);
        send_fields(CMD_POSE, 16'h8000, 16'h8000, 16'h7FFF);
        send_fields(CMD_POSE, 16'h8000, 16'h8000, 16'h8000);
        send_fields(CMD_GOAL, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_fields(CMD_POSE, 16'h7FFF, 16'h8000, 16'h3244);
        send_fields(CMD_POSE, 16'h7FFF, 16'h8000, 16'hCDBC);
        send_fields(CMD_GOAL, 16'h8000, 16'h8000, 16'h0000);
        send_fields(CMD_POSE, 16'h7FFF, 16'h7FFF, 16'h5555);
        send_fields(CMD_POSE, 16'h7FFF, 16'h8000, 16'hAAAA);
        send_fields(CMD_GOAL, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // Mostly a goal followed by poses nearby with plausible headings; the
    // rest has coordinates and headings over the whole range.
    task automatic random_traffic(input int count);
        logic [15:0] gx;
        logic [15:0] gy;
        logic [15:0] h;
        int          near;
        gx = 16'($urandom_range(0, 65535));
        gy = 16'($urandom_range(0, 65535));
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 15)
            begin
                gx = 16'($urandom_range(0, 65535));
                gy = 16'($urandom_range(0, 65535));
                send_fields(CMD_GOAL, gx, gy, 16'($urandom_range(0, 65535)));
            end
            else if ($urandom_range(99) < 70)
            begin
                near = $urandom_range(0, 1) ? 255 : 4095;
                h    = 16'($signed($urandom_range(0, 2 * 12868)) - 12868);
                send_fields(CMD_POSE,
                            gx + 16'($signed($urandom_range(0, 2 * near)) - near),
                            gy + 16'($signed($urandom_range(0, 2 * near)) - near), h);
            end
            else
            begin
                send_fields(CMD_POSE, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end
        end
    endtask

    // The receiver refuses results for a long stretch while the sender keeps
    // offering requests with no gaps, so the block fills and stalls its input.
    task automatic test_receiver_hold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b1;
        random_traffic(12);
    endtask

    // Receiver side: random stalls plus the long hold-off, counted here.
    always @(negedge clk)
    begin
        if (hold_go && hold_left == 0)
        begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker: each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        out_req_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_errors.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: goal_set=%0b angle=%0d along=%0d",
                             out_data.goal_set, $signed(out_data.angle_error),
                             $signed(out_data.along_error));
            end
            else
            begin
                want = pending_errors.pop_front();
                if (out_data.goal_set !== want.goal_set
                    || out_data.angle_error !== want.angle_error
                    || out_data.along_error !== want.along_error)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"Mismatch: expected goal_set=%0b angle=%0d along=%0d,",
                                  " got goal_set=%0b angle=%0d along=%0d"},
                                 want.goal_set, $signed(want.angle_error),
                                 $signed(want.along_error), out_data.goal_set,
                                 $signed(out_data.angle_error),
                                 $signed(out_data.along_error));
                end
            end
        end
    end

    // Watchdog: ends the run if no request moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        model_goal_x    = '0;
        model_goal_y    = '0;
        model_goal_seen = 1'b0;
        model_pose_x    = '0;
        model_pose_y    = '0;
        model_heading   = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_before_goal();
        test_directed_cases();
        drain_results();

        // Sender idles rarely, receiver often.
        send_idle_pct = 15;
        recv_idle_pct = 52;
        random_traffic(580);
        // Pause until every result is back before switching the mix.
        drain_results();

        send_idle_pct = 52;
        recv_idle_pct = 15;
        random_traffic(580);

        test_receiver_hold();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(580);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_errors.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/gtg_pkg.sv
rtl/core/gtg_front.sv
rtl/core/gtg_queue.sv
rtl/core/gtg_back.sv
rtl/core/go_to_goal_pose_error.sv
verif/go_to_goal_pose_error_tb.sv
